### rtl/core/imh_pkg.sv
// Package: shared types and constants for the indexed min-heap.
package imh_pkg;
  localparam int unsigned HeapCapacity = 1024;
  localparam int unsigned KeyWidth = 32;

  localparam logic [2:0] MODE_INSERT = 3'd0;
  localparam logic [2:0] MODE_DEL_MIN = 3'd1;
  localparam logic [2:0] MODE_DEL_HANDLE = 3'd2;
  localparam logic [2:0] MODE_CHANGE = 3'd3;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_NOT_LIVE = 2'd3;

  typedef struct packed {
    logic [2:0] mode;
    logic signed [31:0] key_value;
    logic [9:0] handle;
  } req_t;

  typedef struct packed {
    logic signed [31:0] min_value;
    logic heap_empty;
    logic [10:0] entry_count;
    logic [9:0] new_handle;
    logic [1:0] status;
  } rsp_t;
endpackage

### rtl/core/indexed_min_heap_top.sv
// Top level: indexed binary min-heap, keys, handles and live marks held in RAMs.
// An issued but removed handle is found dead by a read of the handle table;
// each sift-up or sift-down level does RAM reads and writes per exchange.
// Throughput: one request at a time, taken once the response register is free.
// Reset clears size and handle counter; handles not yet issued read as dead.
module indexed_min_heap_top #(
  parameter int unsigned HeapCapacity = imh_pkg::HeapCapacity,
  parameter int unsigned KeyWidth = imh_pkg::KeyWidth
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           req_valid_i,
  output logic           req_ready_o,
  input  imh_pkg::req_t  req_i,
  output logic           rsp_valid_o,
  input  logic           rsp_ready_i,
  output imh_pkg::rsp_t  rsp_o
);
  import imh_pkg::*;

  localparam int unsigned AW = $clog2(HeapCapacity);
  localparam int unsigned CW = AW + 1;

  typedef enum logic [4:0] {
    S_IDLE, S_DISPATCH, S_INS, S_LOOK, S_LOOK_W, S_RM_A, S_RM_B, S_RM_C, S_RM_W,
    S_RM_K, S_RM_KW, S_SET_W, S_DN_P, S_DN_L, S_DN_R, S_DN_RW, S_UP_P, S_UP_Q,
    S_UP_QW, S_X1, S_X2, S_X3, S_X4, S_X5, S_MIN, S_MIN_W, S_DONE
  } state_e;

  state_e state_q;
  req_t req_q;
  logic [CW-1:0] size_q, next_q;
  logic [AW-1:0] p_q, q_q, best_q;
  logic [KeyWidth-1:0] kp_q, kq_q, kb_q;
  logic [AW-1:0] hp_q;
  logic up_q, rm_q;
  logic [1:0] st_q;
  logic [AW-1:0] nh_q;
  logic rsp_valid_q;
  rsp_t rsp_q;

  logic k_we, p2h_we, h2p_we;
  logic [AW-1:0] k_a, p2h_a, h2p_a, p2h_wd, p2h_rd;
  logic [AW:0] h2p_wd, h2p_rd;
  logic [KeyWidth-1:0] k_wd, k_rd, key_in;

  imh_ram #(.Width(KeyWidth), .Depth(HeapCapacity)) u_key (
    .clk_i, .we_i(k_we), .addr_i(k_a), .wdata_i(k_wd), .rdata_o(k_rd));
  imh_ram #(.Width(AW), .Depth(HeapCapacity)) u_p2h (
    .clk_i, .we_i(p2h_we), .addr_i(p2h_a), .wdata_i(p2h_wd), .rdata_o(p2h_rd));
  imh_ram #(.Width(AW + 1), .Depth(HeapCapacity)) u_h2p (
    .clk_i, .we_i(h2p_we), .addr_i(h2p_a), .wdata_i(h2p_wd), .rdata_o(h2p_rd));

  assign key_in = KeyWidth'(req_q.key_value);
  assign req_ready_o = (state_q == S_IDLE) && !rsp_valid_q;
  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o = rsp_q;

  logic [CW:0] lchild, rchild;
  logic [AW-1:0] last_pos, parent;
  logic h_ok;
  assign lchild = {p_q, 1'b1} + (CW+1)'(0);
  assign rchild = lchild + (CW+1)'(1);
  assign last_pos = AW'(size_q - CW'(1));
  assign parent = AW'((p_q - AW'(1)) >> 1);
  assign h_ok = (32'(req_q.handle) < 32'(HeapCapacity)) &&
                (32'(req_q.handle) < 32'(next_q));

  always_comb begin
    k_we = 1'b0; p2h_we = 1'b0; h2p_we = 1'b0;
    k_a = p_q; p2h_a = p_q; h2p_a = AW'(req_q.handle);
    k_wd = kp_q; p2h_wd = hp_q; h2p_wd = {1'b1, p_q};
    case (state_q)
      S_INS: begin
        k_we = 1'b1; p2h_we = 1'b1; h2p_we = 1'b1;
        k_a = AW'(size_q); p2h_a = AW'(size_q); h2p_a = AW'(next_q);
        k_wd = key_in; p2h_wd = AW'(next_q); h2p_wd = {1'b1, AW'(size_q)};
      end
      S_LOOK: h2p_a = AW'(req_q.handle);
      S_RM_B: begin
        p2h_a = last_pos; k_a = last_pos;
        h2p_we = 1'b1; h2p_a = p2h_rd; h2p_wd = '0;
      end
      S_RM_C: begin
        p2h_we = 1'b1; k_we = 1'b1; h2p_we = (p_q != last_pos);
        h2p_a = p2h_rd; h2p_wd = {1'b1, p_q}; p2h_wd = p2h_rd; k_wd = k_rd;
      end
      S_SET_W: begin k_we = 1'b1; k_wd = key_in; end
      S_DN_P: k_a = p_q;
      S_DN_L: k_a = AW'(lchild);
      S_DN_R: k_a = AW'(rchild);
      S_UP_P: k_a = p_q;
      S_UP_Q: k_a = parent;
      S_X1: p2h_a = p_q;
      S_X2: begin
        p2h_we = 1'b1; p2h_a = q_q; p2h_wd = hp_q;
        k_we = 1'b1; k_a = q_q; k_wd = kp_q;
        h2p_we = 1'b1; h2p_a = hp_q; h2p_wd = {1'b1, q_q};
      end
      S_X3: begin
        p2h_we = 1'b1; p2h_a = p_q; p2h_wd = p2h_rd;
        k_we = 1'b1; k_a = p_q; k_wd = kq_q;
        h2p_we = 1'b1; h2p_a = p2h_rd; h2p_wd = {1'b1, p_q};
      end
      S_MIN: k_a = '0;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; size_q <= '0; next_q <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (rsp_valid_q && rsp_ready_i) rsp_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: if (req_valid_i && req_ready_o) begin
          req_q <= req_i; st_q <= ST_OK; nh_q <= '0; state_q <= S_DISPATCH;
        end
        S_DISPATCH: begin
          case (req_q.mode)
            MODE_INSERT:
              if (32'(size_q) >= 32'(HeapCapacity) || 32'(next_q) >= 32'(HeapCapacity)) begin
                st_q <= ST_FULL; state_q <= S_MIN;
              end else state_q <= S_INS;
            MODE_DEL_MIN:
              if (size_q == '0) begin st_q <= ST_EMPTY; state_q <= S_MIN; end
              else begin p_q <= '0; state_q <= S_RM_A; end
            MODE_DEL_HANDLE, MODE_CHANGE:
              if (!h_ok) begin st_q <= ST_NOT_LIVE; state_q <= S_MIN; end
              else state_q <= S_LOOK;
            default: state_q <= S_MIN;
          endcase
        end
        S_INS: begin
          nh_q <= AW'(next_q);
          p_q <= AW'(size_q); kp_q <= key_in;
          next_q <= next_q + CW'(1); size_q <= size_q + CW'(1);
          state_q <= S_UP_P;
        end
        S_LOOK: state_q <= S_LOOK_W;
        S_LOOK_W: begin
          if (!h2p_rd[AW]) begin
            st_q <= ST_NOT_LIVE; state_q <= S_MIN;
          end else begin
            p_q <= h2p_rd[AW-1:0];
            state_q <= (req_q.mode == MODE_CHANGE) ? S_SET_W : S_RM_A;
          end
        end
        S_RM_A: state_q <= S_RM_B;
        S_RM_B: state_q <= S_RM_C;
        S_RM_C: begin
          size_q <= size_q - CW'(1);
          state_q <= (32'(p_q) < 32'(size_q - CW'(1))) ? S_DN_P : S_MIN;
        end
        S_SET_W: state_q <= S_DN_P;
        S_DN_P: state_q <= S_DN_L;
        S_DN_L: begin kp_q <= k_rd; kb_q <= k_rd; best_q <= p_q; state_q <= S_DN_R; end
        S_DN_R: begin
          if (32'(lchild) < 32'(size_q) && $signed(k_rd) < $signed(kb_q)) begin
            kb_q <= k_rd; best_q <= AW'(lchild);
          end
          state_q <= S_DN_RW;
        end
        S_DN_RW: begin
          if (32'(rchild) < 32'(size_q) && $signed(k_rd) < $signed(kb_q)) begin
            q_q <= AW'(rchild); kq_q <= k_rd; up_q <= 1'b0; state_q <= S_X1;
          end else if (best_q != p_q) begin
            q_q <= best_q; kq_q <= kb_q; up_q <= 1'b0; state_q <= S_X1;
          end else state_q <= S_UP_P;
        end
        S_UP_P: state_q <= S_UP_Q;
        S_UP_Q: begin kp_q <= k_rd; state_q <= S_UP_QW; end
        S_UP_QW: begin
          if (p_q != '0 && $signed(kp_q) < $signed(k_rd)) begin
            q_q <= parent; kq_q <= k_rd; up_q <= 1'b1; state_q <= S_X1;
          end else state_q <= S_MIN;
        end
        S_X1: state_q <= S_X4;
        S_X4: begin hp_q <= p2h_rd; state_q <= S_X5; end
        S_X5: state_q <= S_X2;
        S_X2: state_q <= S_X3;
        S_X3: begin
          p_q <= q_q;
          state_q <= up_q ? S_UP_P : S_DN_P;
        end
        S_MIN: state_q <= S_MIN_W;
        S_MIN_W: begin
          rsp_q.min_value <= (size_q != '0) ? 32'($signed(k_rd)) : '0;
          rsp_q.heap_empty <= (size_q == '0);
          rsp_q.entry_count <= 11'(size_q);
          rsp_q.new_handle <= 10'(nh_q);
          rsp_q.status <= st_q;
          rsp_valid_q <= 1'b1;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // hp_q holds the handle at p (read in X1); the read-first access at q in X2
  // returns the handle at q for X3.

`ifndef ASSERT_OFF
  a_no_overfill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(size_q) <= 32'(HeapCapacity)) else $error("heap size overflow");
  a_size_le_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    size_q <= next_q) else $error("more entries than handles issued");
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_q && !rsp_ready_i |=> rsp_valid_q && $stable(rsp_q))
    else $error("response changed while stalled");
`endif
endmodule

### rtl/core/imh_ram.sv
// Generic single-port RAM with registered read.
module imh_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

### bench/tb_top.sv
// Testbench for the indexed min-heap: directed table, random ops, self-checking predictor.
`timescale 1ns / 1ps

module tb_top;
  import imh_pkg::*;

  localparam logic [2:0] MODE_QUERY = 3'd4;
  localparam int unsigned Cap = HeapCapacity;
  localparam int StallLimit = 3000;
  localparam int HoldCycles = 400;

  typedef struct {
    logic [2:0] mode;
    logic signed [31:0] key;
    logic [9:0] handle;
    bit typed;
    rsp_t rsp;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req_q = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  indexed_min_heap_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_valid_i(req_valid),
    .req_ready_o(req_ready),
    .req_i      (req_q),
    .rsp_valid_o(rsp_valid),
    .rsp_ready_i(rsp_ready),
    .rsp_o      (rsp)
  );

  // heap shadow
  logic signed [31:0] hkey [Cap];
  logic [9:0] pos_hdl [Cap];
  logic [9:0] hdl_pos [Cap];
  bit hdl_live [Cap];
  int unsigned hsize;
  int unsigned next_hdl;

  rsp_t expected_rsp[$];
  row_t dir_tab[$];
  int errors = 0;
  int rsp_seen = 0;
  int idle_tx = 0;
  int idle_rx = 0;
  int stall_cnt = 0;
  bit hold_done = 1'b0;

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  function automatic void swap_pos(int unsigned p, int unsigned q);
    logic [9:0] hp, hq;
    logic signed [31:0] k;
    hp = pos_hdl[p];
    hq = pos_hdl[q];
    k = hkey[p];
    hdl_pos[hp] = 10'(q);
    hdl_pos[hq] = 10'(p);
    pos_hdl[p] = hq;
    pos_hdl[q] = hp;
    hkey[p] = hkey[q];
    hkey[q] = k;
  endfunction

  function automatic void sift_up(int unsigned p);
    int unsigned par;
    while (p > 0) begin
      par = (p - 1) / 2;
      if (!(hkey[p] < hkey[par])) break;
      swap_pos(p, par);
      p = par;
    end
  endfunction

  function automatic void sift_down(int unsigned p);
    int unsigned best, l, r;
    forever begin
      best = p;
      l = 2 * p + 1;
      r = l + 1;
      if (l < hsize && hkey[l] < hkey[best]) best = l;
      if (r < hsize && hkey[r] < hkey[best]) best = r;
      if (best == p) break;
      swap_pos(p, best);
      p = best;
    end
  endfunction

  function automatic void remove_at(int unsigned p);
    int unsigned last;
    last = hsize - 1;
    hdl_live[pos_hdl[p]] = 1'b0;
    swap_pos(p, last);
    hsize = last;
    if (p < hsize) begin
      sift_down(p);
      sift_up(p);
    end
  endfunction

  function automatic rsp_t heap_apply(req_t r);
    rsp_t o;
    int unsigned p;
    o = '0;
    o.status = ST_OK;
    case (r.mode)
      MODE_INSERT: begin
        if (hsize >= Cap || next_hdl >= Cap) begin
          o.status = ST_FULL;
        end else begin
          p = hsize;
          o.new_handle = next_hdl[9:0];
          hkey[p] = r.key_value;
          pos_hdl[p] = next_hdl[9:0];
          hdl_pos[next_hdl] = 10'(p);
          hdl_live[next_hdl] = 1'b1;
          next_hdl++;
          hsize++;
          sift_up(p);
        end
      end
      MODE_DEL_MIN: begin
        if (hsize == 0) o.status = ST_EMPTY;
        else remove_at(0);
      end
      MODE_DEL_HANDLE, MODE_CHANGE: begin
        if (!hdl_live[r.handle]) begin
          o.status = ST_NOT_LIVE;
        end else begin
          p = 32'(hdl_pos[r.handle]);
          if (r.mode == MODE_DEL_HANDLE) begin
            remove_at(p);
          end else begin
            hkey[p] = r.key_value;
            sift_down(p);
            sift_up(p);
          end
        end
      end
      default: ;
    endcase
    o.min_value = hsize != 0 ? hkey[0] : '0;
    o.heap_empty = hsize == 0;
    o.entry_count = hsize[10:0];
    return o;
  endfunction

  task automatic report(string field, logic [31:0] got, logic [31:0] want);
    $display("mismatch rsp %0d %s: got %0h expected %0h", rsp_seen, field, got, want);
    errors++;
  endtask

  task automatic send(req_t r, bit typed, rsp_t typed_rsp);
    rsp_t p;
    if ($urandom_range(99) < idle_tx) begin
      req_valid <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < idle_tx) @(posedge clk_i);
    end
    req_valid <= 1'b1;
    req_q <= r;
    do @(posedge clk_i); while (!req_ready);
    p = heap_apply(r);
    expected_rsp.push_back(typed ? typed_rsp : p);
  endtask

  function automatic logic signed [31:0] rand_key();
    case ($urandom_range(9))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2, 3: return $signed($urandom_range(7)) - 3;
      4: return $signed($urandom_range(40)) - 20;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [9:0] pick_handle();
    logic [9:0] h;
    if (next_hdl == 0 || $urandom_range(9) == 0) return 10'($urandom_range(Cap - 1));
    for (int i = 0; i < 8; i++) begin
      h = 10'($urandom_range(next_hdl - 1));
      if (hdl_live[h]) return h;
    end
    return h;
  endfunction

  function automatic req_t rand_req();
    req_t r;
    int unsigned sel;
    sel = $urandom_range(99);
    r.key_value = rand_key();
    r.handle = 10'($urandom_range(Cap - 1));
    if (sel < 36) r.mode = MODE_INSERT;
    else if (sel < 52) r.mode = MODE_DEL_MIN;
    else if (sel < 68) r.mode = MODE_DEL_HANDLE;
    else if (sel < 88) r.mode = MODE_CHANGE;
    else if (sel < 95) r.mode = MODE_QUERY;
    else r.mode = 3'($urandom_range(7, 5));
    if (r.mode == MODE_DEL_HANDLE || r.mode == MODE_CHANGE) r.handle = pick_handle();
    return r;
  endfunction

  always @(posedge clk_i) begin
    if (rsp_valid && rsp_ready) begin
      if (expected_rsp.size() == 0) begin
        $display("unexpected response %0d", rsp_seen);
        errors++;
      end else begin
        rsp_t e;
        e = expected_rsp.pop_front();
        if (rsp.min_value !== e.min_value) report("min_value", rsp.min_value, e.min_value);
        if (rsp.heap_empty !== e.heap_empty) report("heap_empty", rsp.heap_empty, e.heap_empty);
        if (rsp.entry_count !== e.entry_count)
          report("entry_count", rsp.entry_count, e.entry_count);
        if (rsp.new_handle !== e.new_handle) report("new_handle", rsp.new_handle, e.new_handle);
        if (rsp.status !== e.status) report("status", rsp.status, e.status);
      end
      rsp_seen++;
    end
  end

  // receiver with one long hold-off
  initial begin
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (!hold_done && rsp_seen >= 60) begin
        hold_done = 1'b1;
        rsp_ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end
      rsp_ready <= $urandom_range(99) >= idle_rx;
    end
  end

  always @(posedge clk_i) begin
    if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) stall_cnt <= 0;
    else if (rst_ni) stall_cnt <= stall_cnt + 1;
    if (stall_cnt >= StallLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    req_t r;
    rsp_t none;
    none = '0;
    for (int i = 0; i < Cap; i++) hdl_live[i] = 1'b0;
    hsize = 0;
    next_hdl = 0;

    dir_tab.push_back('{MODE_QUERY, 32'sd0, 10'd0, 1'b1, '{32'sd0, 1'b1, 11'd0, 10'd0, ST_OK}});
    dir_tab.push_back('{MODE_DEL_MIN, 32'sd0, 10'd0, 1'b1,
                        '{32'sd0, 1'b1, 11'd0, 10'd0, ST_EMPTY}});
    dir_tab.push_back('{MODE_DEL_HANDLE, 32'sd0, 10'd0, 1'b1,
                        '{32'sd0, 1'b1, 11'd0, 10'd0, ST_NOT_LIVE}});
    dir_tab.push_back('{MODE_CHANGE, 32'sh7fffffff, 10'd1023, 1'b1,
                        '{32'sd0, 1'b1, 11'd0, 10'd0, ST_NOT_LIVE}});
    dir_tab.push_back('{MODE_INSERT, 32'sh7fffffff, 10'd1023, 1'b1,
                        '{32'sh7fffffff, 1'b0, 11'd1, 10'd0, ST_OK}});
    dir_tab.push_back('{MODE_INSERT, 32'sh80000000, 10'd0, 1'b1,
                        '{32'sh80000000, 1'b0, 11'd2, 10'd1, ST_OK}});
    dir_tab.push_back('{MODE_INSERT, 32'sd0, 10'd0, 1'b0, none});
    dir_tab.push_back('{MODE_INSERT, 32'sd5, 10'd0, 1'b0, none});
    dir_tab.push_back('{MODE_INSERT, 32'sd5, 10'd0, 1'b0, none});
    dir_tab.push_back('{MODE_INSERT, 32'sd5, 10'd0, 1'b0, none});
    dir_tab.push_back('{3'd5, -32'sd1, 10'd1023, 1'b0, none});
    dir_tab.push_back('{3'd6, 32'sd0, 10'd0, 1'b0, none});
    dir_tab.push_back('{3'd7, 32'sh7fffffff, 10'd512, 1'b0, none});
    dir_tab.push_back('{MODE_CHANGE, 32'sd100, 10'd1, 1'b0, none});
    dir_tab.push_back('{MODE_CHANGE, -32'sd100, 10'd0, 1'b0, none});
    dir_tab.push_back('{MODE_CHANGE, 32'sd5, 10'd2, 1'b0, none});
    dir_tab.push_back('{MODE_DEL_HANDLE, 32'sd0, 10'd5, 1'b0, none});
    dir_tab.push_back('{MODE_DEL_HANDLE, 32'sd0, 10'd2, 1'b0, none});
    dir_tab.push_back('{MODE_DEL_HANDLE, 32'sd0, 10'd2, 1'b0, none});
    dir_tab.push_back('{MODE_DEL_MIN, 32'sd0, 10'd0, 1'b0, none});
    dir_tab.push_back('{MODE_DEL_MIN, 32'sd0, 10'd0, 1'b0, none});
    dir_tab.push_back('{MODE_QUERY, 32'sd0, 10'd0, 1'b0, none});

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    idle_tx = 18;
    idle_rx = 57;
    foreach (dir_tab[i]) begin
      r.mode = dir_tab[i].mode;
      r.key_value = dir_tab[i].key;
      r.handle = dir_tab[i].handle;
      send(r, dir_tab[i].typed, dir_tab[i].rsp);
    end
    for (int ph = 0; ph < 3; ph++) begin
      idle_tx = ph == 0 ? 18 : (ph == 1 ? 57 : 0);
      idle_rx = ph == 0 ? 57 : (ph == 1 ? 18 : 0);
      for (int i = 0; i < 225; i++) send(rand_req(), 1'b0, none);
    end
    for (int i = 0; i < 20; i++) send(rand_req(), 1'b0, none);
    req_valid <= 1'b0;

    while (expected_rsp.size() != 0) @(posedge clk_i);
    repeat (150) @(posedge clk_i);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule

### filelist.f
rtl/core/imh_pkg.sv
rtl/core/imh_ram.sv
rtl/core/indexed_min_heap_top.sv
bench/tb_top.sv
